>>> hw/rtl/line_center_pd_steering_top_defines.svh
// Assertion helpers for the line center PD steering block.
`ifndef LINE_CENTER_PD_STEERING_TOP_DEFINES_SVH
`define LINE_CENTER_PD_STEERING_TOP_DEFINES_SVH

// Check that a condition implies another condition in the same cycle.
`define LCPD_ASSERT_SAME(lbl, cond, expct) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expct)) \
    else $error("lcpd: same-cycle check failed");

// Check that a condition implies another condition in the next cycle.
`define LCPD_ASSERT_NEXT(lbl, cond, expct) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
    else $error("lcpd: next-cycle check failed");

`endif

>>> hw/rtl/lcpd_pkg.sv
package lcpd_pkg;

  // Field widths fixed by the interface
  localparam int GAIN_W   = 16;
  localparam int SPEED_W  = 16;
  localparam int CENTER_W = 10;
  localparam int DRIVE_W  = 27;

  typedef logic [1:0]          outcome_t;
  typedef logic [1:0]          cfg_idx_t;
  typedef logic [CENTER_W-1:0] center_t;
  typedef logic [SPEED_W-1:0]  speed_t;

  // Result outcome codes
  localparam outcome_t OUT_STEER = 2'd0;
  localparam outcome_t OUT_LOST  = 2'd1;
  localparam outcome_t OUT_AMBIG = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_PROP_GAIN    = 2'd0;
  localparam cfg_idx_t CFG_DERIV_GAIN   = 2'd1;
  localparam cfg_idx_t CFG_CRUISE_SPEED = 2'd2;

  // Configuration reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd256;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd0;
  localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 16'd82;

  // Edge counter saturation and the count that means a clean line
  localparam logic [1:0] EDGE_SAT = 2'd3;
  localparam logic [1:0] EDGE_TWO = 2'd2;

endpackage

>>> hw/rtl/line_center_pd_steering_top.sv
// A row-end pixel's steering result passes through stage 1, stage 2 and the output register.
// Throughput: one pixel per cycle while in_stall is low; the row scan registers update on every
// accepted pixel and the three result stages move together whenever the output is free.
// Reset (rst_n low at a clock edge, synchronous): row state, last error and valid bits
// clear, and the gains and cruise speed return to 1.0, 0.0 and 82/256.
`include "line_center_pd_steering_top_defines.svh"

module line_center_pd_steering_top #(
  parameter int MAX_ROW_PIXELS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_pixel_on,
  input  logic                              in_row_end,
  // steering result
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcpd_pkg::outcome_t                out_outcome,
  output lcpd_pkg::center_t                 out_line_center,
  output logic signed [lcpd_pkg::DRIVE_W-1:0] out_steer_drive,
  output lcpd_pkg::speed_t                  out_forward_drive,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  lcpd_pkg::cfg_idx_t                cfg_index,
  input  logic [15:0]                       cfg_data
);
  import lcpd_pkg::*;

  // Widths derived from the row size
  localparam int CW    = $clog2(MAX_ROW_PIXELS + 1);  // pixel count
  localparam int EW    = $clog2(MAX_ROW_PIXELS);      // edge position
  localparam int ERRW  = CW + 1;                      // signed error
  localparam int DERRW = ERRW + 1;                    // signed error delta
  localparam int SUMW  = GAIN_W + DERRW + 1;          // drive before clamp
  localparam int EXTW  = (SUMW > DRIVE_W + 1) ? SUMW : DRIVE_W + 1;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ROW_PIXELS);
  localparam logic signed [EXTW-1:0] DRV_MAX =
    {{(EXTW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [EXTW-1:0] DRV_MIN =
    {{(EXTW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

  // Configuration registers
  logic [GAIN_W-1:0]  prop_gain_r;
  logic [GAIN_W-1:0]  deriv_gain_r;
  logic [SPEED_W-1:0] cruise_speed_r;

  // Row scan state
  logic          prev_pix_r;
  logic [CW-1:0] pix_cnt_r;
  logic [1:0]    edge_cnt_r;
  logic [EW-1:0] edge0_r;
  logic [EW-1:0] edge1_r;

  // Stage 1: finished row
  logic          s1_v_r;
  logic [CW-1:0] s1_cnt_r;
  logic [1:0]    s1_ec_r;
  logic [EW-1:0] s1_e0_r;
  logic [EW-1:0] s1_e1_r;

  // Stage 2: center and error
  logic                     s2_v_r;
  logic                     s2_steer_r;
  logic [1:0]               s2_ec_r;
  logic [EW-1:0]            s2_center_r;
  logic signed [ERRW-1:0]   s2_err_r;
  logic signed [DERRW-1:0]  s2_derr_r;
  logic signed [ERRW-1:0]   last_err_r;

  // Output register
  logic                       out_v_r;
  outcome_t                   out_outcome_r;
  center_t                    out_center_r;
  logic signed [DRIVE_W-1:0]  out_drive_r;
  speed_t                     out_speed_r;

  logic advance;
  logic accept;

  // Pixel scan combinational
  logic          in_range;
  logic          is_edge;
  logic [EW-1:0] edge_pos;
  logic          prev_pix_nxt;
  logic [CW-1:0] pix_cnt_nxt;
  logic [1:0]    edge_cnt_nxt;
  logic [EW-1:0] edge0_nxt;
  logic [EW-1:0] edge1_nxt;

  // Stage 2 combinational
  logic [EW:0]             center_sum;
  logic [EW-1:0]           center_nxt;
  logic signed [ERRW-1:0]  err_nxt;
  logic signed [DERRW-1:0] derr_nxt;

  // Stage 3 combinational
  logic signed [GAIN_W+ERRW-1:0]  prop_term;
  logic signed [GAIN_W+DERRW-1:0] deriv_term;
  logic signed [EXTW-1:0]         drive_sum;
  logic signed [DRIVE_W-1:0]      drive_sat;

  // Hold the pixel input and all result stages while the output waits
  assign advance   = !(out_v_r && out_stall);
  assign in_stall  = !advance;
  assign accept    = in_valid && advance;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= PROP_GAIN_RST;
      deriv_gain_r   <= DERIV_GAIN_RST;
      cruise_speed_r <= CRUISE_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:    prop_gain_r    <= cfg_data;
        CFG_DERIV_GAIN:   deriv_gain_r   <= cfg_data;
        CFG_CRUISE_SPEED: cruise_speed_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Detect edges and advance the pixel count
  always_comb begin
    in_range     = (pix_cnt_r < MAX_CNT);
    is_edge      = in_range && (pix_cnt_r != '0) && (in_pixel_on != prev_pix_r);
    edge_pos     = EW'(pix_cnt_r - CW'(1));
    prev_pix_nxt = prev_pix_r;
    pix_cnt_nxt  = pix_cnt_r;
    edge_cnt_nxt = edge_cnt_r;
    edge0_nxt    = edge0_r;
    edge1_nxt    = edge1_r;
    if (in_range) begin
      prev_pix_nxt = in_pixel_on;
      pix_cnt_nxt  = pix_cnt_r + CW'(1);
    end
    if (is_edge) begin
      if (edge_cnt_r == 2'd0) begin
        edge0_nxt = edge_pos;
      end
      if (edge_cnt_r == 2'd1) begin
        edge1_nxt = edge_pos;
      end
      if (edge_cnt_r != EDGE_SAT) begin
        edge_cnt_nxt = edge_cnt_r + 2'd1;
      end
    end
  end

  // Row scan state; clear at row end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pix_r <= 1'b0;
      pix_cnt_r  <= '0;
      edge_cnt_r <= '0;
      edge0_r    <= '0;
      edge1_r    <= '0;
    end else if (accept) begin
      if (in_row_end) begin
        prev_pix_r <= 1'b0;
        pix_cnt_r  <= '0;
        edge_cnt_r <= '0;
        edge0_r    <= '0;
        edge1_r    <= '0;
      end else begin
        prev_pix_r <= prev_pix_nxt;
        pix_cnt_r  <= pix_cnt_nxt;
        edge_cnt_r <= edge_cnt_nxt;
        edge0_r    <= edge0_nxt;
        edge1_r    <= edge1_nxt;
      end
    end
  end

  // Stage 1: capture the finished row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= accept && in_row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cnt_r <= pix_cnt_nxt;
      s1_ec_r  <= edge_cnt_nxt;
      s1_e0_r  <= edge0_nxt;
      s1_e1_r  <= edge1_nxt;
    end
  end

  // Stage 2: center, error and error delta
  always_comb begin
    center_sum = {1'b0, s1_e0_r} + {1'b0, s1_e1_r};
    center_nxt = center_sum[EW:1];
    err_nxt    = signed'(ERRW'(s1_cnt_r >> 1)) - signed'(ERRW'(center_nxt));
    derr_nxt   = DERRW'(err_nxt) - DERRW'(last_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r     <= 1'b0;
      last_err_r <= '0;
    end else if (advance) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        last_err_r <= (s1_ec_r == EDGE_TWO) ? err_nxt : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_steer_r  <= (s1_ec_r == EDGE_TWO);
      s2_ec_r     <= s1_ec_r;
      s2_center_r <= center_nxt;
      s2_err_r    <= err_nxt;
      s2_derr_r   <= derr_nxt;
    end
  end

  // Stage 3: PD drive with clamp to the drive range
  always_comb begin
    prop_term  = signed'(prop_gain_r) * s2_err_r;
    deriv_term = signed'(deriv_gain_r) * s2_derr_r;
    drive_sum  = EXTW'(prop_term) + EXTW'(deriv_term);
    if (drive_sum > DRV_MAX) begin
      drive_sat = DRIVE_W'(DRV_MAX);
    end else if (drive_sum < DRV_MIN) begin
      drive_sat = DRIVE_W'(DRV_MIN);
    end else begin
      drive_sat = DRIVE_W'(drive_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s2_steer_r) begin
        out_outcome_r <= OUT_STEER;
        out_center_r  <= CENTER_W'(s2_center_r);
        out_drive_r   <= drive_sat;
        out_speed_r   <= cruise_speed_r;
      end else begin
        out_outcome_r <= (s2_ec_r == 2'd0) ? OUT_LOST : OUT_AMBIG;
        out_center_r  <= '0;
        out_drive_r   <= '0;
        out_speed_r   <= '0;
      end
    end
  end

  assign out_valid         = out_v_r;
  assign out_outcome       = out_outcome_r;
  assign out_line_center   = out_center_r;
  assign out_steer_drive   = out_drive_r;
  assign out_forward_drive = out_speed_r;

  // A row whose edge count is not EDGE_TWO (not a clean line) leaves no error history
  `LCPD_ASSERT_NEXT(a_err_cleared, advance && s1_v_r && (s1_ec_r != EDGE_TWO), last_err_r == '0)

  // A row end restarts the scan
  `LCPD_ASSERT_NEXT(a_row_restart, accept && in_row_end, (pix_cnt_r == '0) && (edge_cnt_r == '0))

  // Lost and ambiguous results carry no drive
  `LCPD_ASSERT_SAME(a_idle_drive, out_v_r && (out_outcome_r != OUT_STEER), (out_drive_r == '0) && (out_speed_r == '0) && (out_center_r == '0))

endmodule
